// ----- rtl/bmh_pkg.sv -----
// Shared constants and item types for the binary min-heap.
package bmh_pkg;

    localparam int HEAP_DEPTH = 1024;
    localparam int ADDR_W     = $clog2(HEAP_DEPTH);
    localparam int CNT_W      = $clog2(HEAP_DEPTH + 1);
    localparam int DATA_W     = 32;
    localparam int OCC_W      = 11;

    localparam logic       REQ_INSERT   = 1'b0;
    localparam logic       REQ_REMOVE   = 1'b1;

    localparam logic [1:0] ST_DONE      = 2'd0;
    localparam logic [1:0] ST_FULL      = 2'd1;
    localparam logic [1:0] ST_EMPTY     = 2'd2;

    typedef struct packed {
        logic                     req_type;
        logic signed [DATA_W-1:0] insert_value;
    } t_req;

    typedef struct packed {
        logic [1:0]               status;
        logic signed [DATA_W-1:0] top_value;
        logic [OCC_W-1:0]         occupancy;
        logic                     is_empty;
    } t_result;

endpackage

// ----- rtl/bmh_ram.sv -----
// Generic RAM: one write port, two read ports, registered read data.
module bmh_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_a,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_b,
    output logic [WIDTH-1:0]         o_rdata_a,
    output logic [WIDTH-1:0]         o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata_a <= r_mem[i_raddr_a];
        o_rdata_b <= r_mem[i_raddr_b];
    end

endmodule

// ----- rtl/binary_min_heap.sv -----
// Binary min-heap priority queue: insert and remove-minimum over a RAM-backed heap.
//
//  channel   direction  handshake                 payload
//  request   in         start & !busy accepts     i_req    (t_req)
//  result    out        o_valid, one cycle only   o_result (t_result)
//
// An insert writes the new entry, then climbs one level per read and compare step; a remove
// loads the last entry, then descends one level per read and compare step.
// Rejected requests, an insert into an empty heap and a remove of the last entry are answered in the next cycle.
// The heap RAM (one write, two read ports) sets the pace: one read round per step.
// Synchronous active-low reset empties the heap; stored entries are not cleared.
// The result strobe cannot be stalled; busy is low in the strobe cycle.
module binary_min_heap
    import bmh_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    start,
    input  t_req    i_req,
    output logic    busy,
    output logic    o_valid,
    output t_result o_result
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_UP_RD  = 3'd1;
    localparam logic [2:0] S_UP_CMP = 3'd2;
    localparam logic [2:0] S_DN_LV  = 3'd3;
    localparam logic [2:0] S_DN_RD  = 3'd4;
    localparam logic [2:0] S_DN_CMP = 3'd5;

    logic [2:0]               r_state,  n_state;
    logic [CNT_W-1:0]         r_fill,   n_fill;
    logic [ADDR_W-1:0]        r_pos,    n_pos;
    logic signed [DATA_W-1:0] r_val,    n_val;
    logic signed [DATA_W-1:0] r_root,   n_root;
    logic                     r_valid,  n_valid;
    logic [1:0]               r_status, n_status;

    logic                     we;
    logic [ADDR_W-1:0]        waddr;
    logic signed [DATA_W-1:0] wdata;
    logic [ADDR_W-1:0]        raddr_a, raddr_b;
    logic [DATA_W-1:0]        rdata_a, rdata_b;
    logic signed [DATA_W-1:0] left_val, right_val, best_val;

    logic [ADDR_W-1:0]        parent;
    logic [CNT_W:0]           lc, rc, fill_x;
    logic [ADDR_W-1:0]        best_pos;
    logic                     take_left;

    bmh_ram #(
        .WIDTH (DATA_W),
        .DEPTH (HEAP_DEPTH)
    ) u_ram (
        .i_clk     (i_clk),
        .i_we      (we),
        .i_waddr   (waddr),
        .i_wdata   (wdata),
        .i_raddr_a (raddr_a),
        .i_raddr_b (raddr_b),
        .o_rdata_a (rdata_a),
        .o_rdata_b (rdata_b)
    );

    assign parent    = ADDR_W'((r_pos - ADDR_W'(1)) >> 1);
    assign lc        = (CNT_W + 1)'({r_pos, 1'b1});
    assign rc        = lc + (CNT_W + 1)'(1);
    assign fill_x    = {1'b0, r_fill};
    assign left_val  = $signed(rdata_a);
    assign right_val = $signed(rdata_b);

    always_comb begin
        take_left = (r_val > left_val);
        best_val  = take_left ? left_val : r_val;
        best_pos  = take_left ? lc[ADDR_W-1:0] : r_pos;
        if ((rc < fill_x) && (best_val > right_val)) begin
            best_val = right_val;
            best_pos = rc[ADDR_W-1:0];
        end
    end

    always_comb begin
        n_state  = r_state;
        n_fill   = r_fill;
        n_pos    = r_pos;
        n_val    = r_val;
        n_valid  = 1'b0;
        n_status = r_status;
        we       = 1'b0;
        waddr    = r_pos;
        wdata    = r_val;
        raddr_a  = parent;
        raddr_b  = rc[ADDR_W-1:0];

        case (r_state)
            S_IDLE: begin
                if (start) begin
                    if (i_req.req_type == REQ_INSERT) begin
                        if (r_fill == CNT_W'(HEAP_DEPTH)) begin
                            n_valid  = 1'b1;
                            n_status = ST_FULL;
                        end else begin
                            we       = 1'b1;
                            waddr    = r_fill[ADDR_W-1:0];
                            wdata    = i_req.insert_value;
                            n_fill   = r_fill + CNT_W'(1);
                            n_pos    = r_fill[ADDR_W-1:0];
                            n_val    = i_req.insert_value;
                            n_status = ST_DONE;
                            if (r_fill == '0) begin
                                n_valid = 1'b1;
                            end else begin
                                n_state = S_UP_RD;
                            end
                        end
                    end else begin
                        if (r_fill == '0) begin
                            n_valid  = 1'b1;
                            n_status = ST_EMPTY;
                        end else begin
                            n_fill   = r_fill - CNT_W'(1);
                            n_status = ST_DONE;
                            raddr_a  = ADDR_W'(r_fill - CNT_W'(1));
                            if (r_fill == CNT_W'(1)) begin
                                n_valid = 1'b1;
                            end else begin
                                n_state = S_DN_LV;
                            end
                        end
                    end
                end
            end
            S_UP_RD: begin
                if (r_pos == '0) begin
                    we      = 1'b1;
                    n_valid = 1'b1;
                    n_state = S_IDLE;
                end else begin
                    n_state = S_UP_CMP;
                end
            end
            S_UP_CMP: begin
                we = 1'b1;
                if (r_val < left_val) begin
                    wdata   = left_val;
                    n_pos   = parent;
                    n_state = S_UP_RD;
                end else begin
                    n_valid = 1'b1;
                    n_state = S_IDLE;
                end
            end
            S_DN_LV: begin
                n_val   = left_val;
                n_pos   = '0;
                n_state = S_DN_RD;
            end
            S_DN_RD: begin
                raddr_a = lc[ADDR_W-1:0];
                if (lc >= fill_x) begin
                    we      = 1'b1;
                    n_valid = 1'b1;
                    n_state = S_IDLE;
                end else begin
                    n_state = S_DN_CMP;
                end
            end
            S_DN_CMP: begin
                we = 1'b1;
                if (best_pos == r_pos) begin
                    n_valid = 1'b1;
                    n_state = S_IDLE;
                end else begin
                    wdata   = best_val;
                    n_pos   = best_pos;
                    n_state = S_DN_RD;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign n_root = (we && (waddr == '0)) ? wdata : r_root;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_fill  <= '0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_fill  <= n_fill;
            r_valid <= n_valid;
        end
        r_pos    <= n_pos;
        r_val    <= n_val;
        r_root   <= n_root;
        r_status <= n_status;
    end

    assign busy                = (r_state != S_IDLE);
    assign o_valid             = r_valid;
    assign o_result.status     = r_status;
    assign o_result.top_value  = (r_fill != '0) ? r_root : '0;
    assign o_result.occupancy  = OCC_W'(r_fill);
    assign o_result.is_empty   = (r_fill == '0);

endmodule
